[src/equirect_to_cube_cross_resampler_unit_assert.svh]
// Assertion macros for the equirect to cube cross resampler checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef EQUIRECT_TO_CUBE_CROSS_RESAMPLER_UNIT_ASSERT_SVH
`define EQUIRECT_TO_CUBE_CROSS_RESAMPLER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define E2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define E2C_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/e2c_pkg.sv]
// Shared constants, codes and types of the equirect to cube cross resampler.
// No dependencies.
package e2c_pkg;

  localparam int FACE_MAX_DEF = 32;
  localparam int CW = 28;
  localparam int ZW = 18;
  localparam int CORDIC_STEPS = 15;

  localparam logic signed [ZW-1:0] ANGLE_STEP [CORDIC_STEPS] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
    18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1
  };
  localparam logic signed [ZW-1:0] QUARTER_TURN = 18'sd16384;
  localparam logic signed [CW-1:0] GAIN_X4 = 28'sd107924;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [2:0] FACE_XN = 3'd0;
  localparam logic [2:0] FACE_YN = 3'd1;
  localparam logic [2:0] FACE_XP = 3'd2;
  localparam logic [2:0] FACE_YP = 3'd3;
  localparam logic [2:0] FACE_ZP = 3'd4;
  localparam logic [2:0] FACE_ZN = 3'd5;

  localparam logic CFG_FACE_SIZE = 1'b0;
  localparam logic CFG_SOURCE_HEIGHT = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic                 is_load;
    logic [6:0]           wx;
    logic [5:0]           wy;
    logic [31:0]          pixel;
    logic [6:0]           dest_x;
    logic [6:0]           dest_y;
    logic signed [CW-1:0] pz_s;
    logic [16:0]          theta;
  } ctx_t;

endpackage

[src/e2c_bank.sv]
// One bank of the source image store: one write port, one registered read port.
// No dependencies.
module e2c_bank #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [1 << AW];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/e2c_cordic.sv]
// Pipelined vectoring CORDIC: pre-rotation stage plus one step per stage.
// Depends on e2c_pkg.
module e2c_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [e2c_pkg::CW-1:0]  vec_x,
  input  logic signed [e2c_pkg::CW-1:0]  vec_y,
  output logic signed [e2c_pkg::CW-1:0]  mag,
  output logic signed [e2c_pkg::ZW-1:0]  ang
);
  import e2c_pkg::*;

  logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS+1];
  logic                 zero_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (vec_x == '0) && (vec_y == '0);
      if (vec_x < 0) begin
        if (vec_y >= 0) begin
          x_r[0] <= vec_y;
          y_r[0] <= -vec_x;
          z_r[0] <= QUARTER_TURN;
        end else begin
          x_r[0] <= -vec_y;
          y_r[0] <= vec_x;
          z_r[0] <= -QUARTER_TURN;
        end
      end else begin
        x_r[0] <= vec_x;
        y_r[0] <= vec_y;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k+1] <= zero_r[k];
        if (y_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ANGLE_STEP[k];
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ANGLE_STEP[k];
        end
      end
    end
  end

  assign mag = x_r[CORDIC_STEPS];
  assign ang = zero_r[CORDIC_STEPS] ? '0 : z_r[CORDIC_STEPS];

endmodule

[src/equirect_to_cube_cross_resampler_unit.sv]
// Top level of the equirect to cube cross resampler: setup, two CORDIC pipelines,
// texel fetch from a four-bank store and bilinear blend. Depends on e2c_pkg,
// e2c_cordic and e2c_bank.
//
//   channel | handshake           | payload
//   cfg     | cfg_we              | cfg_index, cfg_data
//   in      | in_valid / in_ready | opcode, face, column, row, load position, RGBA
//   out     | out_valid/out_ready | cross position, blended RGBA
//
// One beat per cycle while the pipeline is not held; a compute beat passes setup,
// the two 16-stage CORDIC pipelines, coordinate, fetch, multiply and the summing output register.
// Loads write the store in the fetch stage, so they stay ordered with computes.
// rst_n is synchronous; it clears the valid bits and sets the configuration registers to their defaults.
// The pipeline holds only while its last stage and the output register are both full
// and the waiting result is not taken.
module equirect_to_cube_cross_resampler_unit #(
  parameter int FACE_MAX = e2c_pkg::FACE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [2:0] in_face,
  input  logic [4:0] in_face_col,
  input  logic [4:0] in_face_row,
  input  logic [6:0] in_src_x,
  input  logic [5:0] in_src_y,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_dest_x,
  output logic [6:0] out_dest_y,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import e2c_pkg::*;

  localparam int SRC_W = 4 * FACE_MAX;
  localparam int SRC_H = 2 * FACE_MAX;
  localparam int UX_W = $clog2(SRC_W);
  localparam int VY_W = $clog2(SRC_H);
  localparam int XH_W = UX_W - 1;
  localparam int YH_W = (VY_W > 1) ? VY_W - 1 : 1;
  localparam int AW = XH_W + YH_W;
  localparam int DEPTH = CORDIC_STEPS + 1;

  logic [5:0] face_size_r;
  logic [6:0] source_height_r;
  logic [5:0] fs;
  logic [6:0] sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r <= 6'd32;
      source_height_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FACE_SIZE:     face_size_r <= cfg_data[5:0];
        CFG_SOURCE_HEIGHT: source_height_r <= cfg_data;
        default:           face_size_r <= face_size_r;
      endcase
    end
  end

  always_comb begin
    if (face_size_r == '0) begin
      fs = 6'd1;
    end else if (int'(face_size_r) > FACE_MAX) begin
      fs = 6'(FACE_MAX);
    end else begin
      fs = face_size_r;
    end
    if (source_height_r == '0) begin
      sh = 7'd1;
    end else if (int'(source_height_r) > SRC_H) begin
      sh = 7'(SRC_H);
    end else begin
      sh = source_height_r;
    end
  end

  logic en;
  logic s5_valid_r;
  logic out_valid_r;

  assign en = !out_valid_r || out_ready || !s5_valid_r;
  assign in_ready = en;

  // Setup stage.
  ctx_t s1_ctx_nxt, s1_ctx_r;
  logic signed [7:0] px_v, py_v, pz_v, a_v, b_v, nfs_v;
  logic signed [7:0] s1_px_r, s1_py_r;
  logic [7:0] fs8, offx, offy;

  always_comb begin
    fs8 = {2'b00, fs};
    a_v = $signed({2'b00, in_face_col, 1'b0}) - $signed(fs8);
    b_v = $signed({2'b00, in_face_row, 1'b0}) - $signed(fs8);
    nfs_v = -$signed(fs8);
    unique case (in_face)
      FACE_XN: begin
        px_v = nfs_v; py_v = a_v; pz_v = b_v;
        offx = fs8; offy = fs8 + {fs8[6:0], 1'b0};
      end
      FACE_YN: begin
        px_v = a_v; py_v = nfs_v; pz_v = -b_v;
        offx = '0; offy = fs8;
      end
      FACE_XP: begin
        px_v = $signed(fs8); py_v = a_v; pz_v = -b_v;
        offx = fs8; offy = fs8;
      end
      FACE_YP: begin
        px_v = -a_v; py_v = $signed(fs8); pz_v = -b_v;
        offx = {fs8[6:0], 1'b0}; offy = fs8;
      end
      FACE_ZP: begin
        px_v = b_v; py_v = a_v; pz_v = $signed(fs8);
        offx = fs8; offy = '0;
      end
      default: begin
        px_v = -b_v; py_v = a_v; pz_v = nfs_v;
        offx = fs8; offy = {fs8[6:0], 1'b0};
      end
    endcase
    s1_ctx_nxt.valid = in_valid && ((in_opcode == OP_LOAD) || (in_face <= FACE_ZN));
    s1_ctx_nxt.is_load = (in_opcode == OP_LOAD);
    s1_ctx_nxt.wx = in_src_x;
    s1_ctx_nxt.wy = in_src_y;
    s1_ctx_nxt.pixel = {in_alpha, in_blue, in_green, in_red};
    s1_ctx_nxt.dest_x = 7'({3'b000, in_face_col} + offx);
    s1_ctx_nxt.dest_y = 7'({3'b000, in_face_row} + offy);
    s1_ctx_nxt.pz_s = CW'(pz_v) * GAIN_X4;
    s1_ctx_nxt.theta = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctx_r.valid <= 1'b0;
    end else if (en) begin
      s1_ctx_r <= s1_ctx_nxt;
      s1_px_r <= px_v;
      s1_py_r <= py_v;
    end
  end

  // Azimuth.
  logic signed [CW-1:0] th_x_in, th_y_in, th_mag;
  logic signed [ZW-1:0] th_ang;
  ctx_t line1_r [DEPTH];

  assign th_x_in = {{(CW-24){s1_px_r[7]}}, s1_px_r, 16'h0000};
  assign th_y_in = {{(CW-24){s1_py_r[7]}}, s1_py_r, 16'h0000};

  e2c_cordic u_theta (
    .clk   (clk),
    .en    (en),
    .vec_x (th_x_in),
    .vec_y (th_y_in),
    .mag   (th_mag),
    .ang   (th_ang)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        line1_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      line1_r[0] <= s1_ctx_r;
      for (int k = 1; k < DEPTH; k++) begin
        line1_r[k] <= line1_r[k-1];
      end
    end
  end

  // Elevation.
  logic signed [ZW:0] th_sum;
  logic [16:0] theta_c;
  ctx_t line2_nxt;
  ctx_t line2_r [DEPTH];
  logic signed [ZW-1:0] ph_ang;

  always_comb begin
    th_sum = $signed({th_ang[ZW-1], th_ang}) + 19'sd32768;
    if (th_sum < 0) begin
      theta_c = '0;
    end else if (th_sum > 19'sd65536) begin
      theta_c = 17'd65536;
    end else begin
      theta_c = th_sum[16:0];
    end
    line2_nxt = line1_r[DEPTH-1];
    line2_nxt.theta = theta_c;
  end

  e2c_cordic u_phi (
    .clk   (clk),
    .en    (en),
    .vec_x (th_mag),
    .vec_y (line1_r[DEPTH-1].pz_s),
    .mag   (),
    .ang   (ph_ang)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        line2_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      line2_r[0] <= line2_nxt;
      for (int k = 1; k < DEPTH; k++) begin
        line2_r[k] <= line2_r[k-1];
      end
    end
  end

  // Source coordinates in Q.8.
  logic signed [ZW-1:0] phi_c, pv_s;
  logic [22:0] fu;
  logic [21:0] fv;
  ctx_t s3_ctx_r;
  logic [16:0] s3_u_r;
  logic [15:0] s3_v_r;

  always_comb begin
    if (ph_ang < -QUARTER_TURN) begin
      phi_c = -QUARTER_TURN;
    end else if (ph_ang > QUARTER_TURN) begin
      phi_c = QUARTER_TURN;
    end else begin
      phi_c = ph_ang;
    end
    pv_s = QUARTER_TURN - phi_c;
    fu = 23'(fs) * 23'(line2_r[DEPTH-1].theta);
    fv = 22'(fs) * 22'(pv_s[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctx_r.valid <= 1'b0;
    end else if (en) begin
      s3_ctx_r <= line2_r[DEPTH-1];
      s3_u_r <= fu[22:6];
      s3_v_r <= fv[21:6];
    end
  end

  // Neighbor clamp, weights and store access.
  logic [7:0] s_w, t_w, ulim, u1, u2;
  logic [6:0] vlim, v1, v2;
  logic [8:0] si, ti;
  logic [17:0] w00, w10, w01, w11;
  logic [15:0] u1w, u1p1, v1w, v1p1, wxw, wyw;
  logic [XH_W-1:0] xh_even, xh_odd;
  logic [YH_W-1:0] yh_even, yh_odd;
  logic [AW-1:0] waddr;
  logic wr_ok;

  always_comb begin
    s_w = s3_u_r[7:0];
    t_w = s3_v_r[7:0];
    ulim = {fs, 2'b00} - 8'd1;
    u1 = (s3_u_r[16:8] > {1'b0, ulim}) ? ulim : s3_u_r[15:8];
    u2 = (u1 == ulim) ? u1 : u1 + 8'd1;
    vlim = sh - 7'd1;
    v1 = (s3_v_r[15:8] > {1'b0, vlim}) ? vlim : s3_v_r[14:8];
    v2 = (v1 == vlim) ? v1 : v1 + 7'd1;
    si = 9'd256 - {1'b0, s_w};
    ti = 9'd256 - {1'b0, t_w};
    w00 = 18'(si) * 18'(ti);
    w10 = 18'(s_w) * 18'(ti);
    w01 = 18'(si) * 18'(t_w);
    w11 = 18'(s_w) * 18'(t_w);
    u1w = 16'(u1);
    u1p1 = u1w + 16'd1;
    v1w = 16'(v1);
    v1p1 = v1w + 16'd1;
    xh_even = u1p1[XH_W:1];
    xh_odd = u1w[XH_W:1];
    yh_even = v1p1[YH_W:1];
    yh_odd = v1w[YH_W:1];
    wxw = 16'(s3_ctx_r.wx);
    wyw = 16'(s3_ctx_r.wy);
    waddr = {wyw[YH_W:1], wxw[XH_W:1]};
    wr_ok = (int'(s3_ctx_r.wx) < SRC_W) && (int'(s3_ctx_r.wy) < SRC_H);
  end

  logic [31:0] bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = (b % 2) == 1;
    localparam logic BY = (b / 2) == 1;
    logic [AW-1:0] raddr;
    logic we, re;
    assign raddr = {(BY ? yh_odd : yh_even), (BX ? xh_odd : xh_even)};
    assign we = en && s3_ctx_r.valid && s3_ctx_r.is_load && wr_ok &&
                (s3_ctx_r.wx[0] == BX) && (s3_ctx_r.wy[0] == BY);
    assign re = en && s3_ctx_r.valid && !s3_ctx_r.is_load;
    e2c_bank #(.AW(AW)) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (s3_ctx_r.pixel),
      .re    (re),
      .raddr (raddr),
      .rdata (bank_q[b])
    );
  end

  logic s4_valid_r;
  logic [6:0] s4_dx_r, s4_dy_r;
  logic s4_u1p_r, s4_u2p_r, s4_v1p_r, s4_v2p_r;
  logic [16:0] s4_w_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_ctx_r.valid && !s3_ctx_r.is_load;
      s4_dx_r <= s3_ctx_r.dest_x;
      s4_dy_r <= s3_ctx_r.dest_y;
      s4_u1p_r <= u1[0];
      s4_u2p_r <= u2[0];
      s4_v1p_r <= v1[0];
      s4_v2p_r <= v2[0];
      s4_w_r[0] <= w00[16:0];
      s4_w_r[1] <= w10[16:0];
      s4_w_r[2] <= w01[16:0];
      s4_w_r[3] <= w11[16:0];
    end
  end

  // Weighted texels.
  logic [31:0] texel [4];
  logic [6:0] s5_dx_r, s5_dy_r;
  logic [24:0] prod_r [4][4];

  always_comb begin
    texel[0] = bank_q[{s4_v1p_r, s4_u1p_r}];
    texel[1] = bank_q[{s4_v1p_r, s4_u2p_r}];
    texel[2] = bank_q[{s4_v2p_r, s4_u1p_r}];
    texel[3] = bank_q[{s4_v2p_r, s4_u2p_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
      s5_dx_r <= s4_dx_r;
      s5_dy_r <= s4_dy_r;
      for (int c = 0; c < 4; c++) begin
        for (int n = 0; n < 4; n++) begin
          prod_r[c][n] <= 25'(texel[n][8*c +: 8]) * 25'(s4_w_r[n]);
        end
      end
    end
  end

  // Sum, round and output register.
  logic [26:0] sum [4];
  logic [7:0] chan [4];
  logic [6:0] out_dest_x_r, out_dest_y_r;
  logic [7:0] out_chan_r [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = 27'(prod_r[c][0]) + 27'(prod_r[c][1]) + 27'(prod_r[c][2]) +
               27'(prod_r[c][3]) + 27'd32768;
      chan[c] = sum[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && s5_valid_r) begin
      out_valid_r <= 1'b1;
      out_dest_x_r <= s5_dx_r;
      out_dest_y_r <= s5_dy_r;
      for (int c = 0; c < 4; c++) begin
        out_chan_r[c] <= chan[c];
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dest_x = out_dest_x_r;
  assign out_dest_y = out_dest_y_r;
  assign out_red = out_chan_r[0];
  assign out_green = out_chan_r[1];
  assign out_blue = out_chan_r[2];
  assign out_alpha = out_chan_r[3];

endmodule

[src/e2c_checker.sv]
// Port-level checker for the equirect to cube cross resampler, bound to the top.
// Depends on equirect_to_cube_cross_resampler_unit_assert.svh.
`include "equirect_to_cube_cross_resampler_unit_assert.svh"

module e2c_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic       cfg_index,
  input logic [6:0] cfg_data,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_opcode,
  input logic [2:0] in_face,
  input logic [4:0] in_face_col,
  input logic [4:0] in_face_row,
  input logic [6:0] in_src_x,
  input logic [5:0] in_src_y,
  input logic [7:0] in_red,
  input logic [7:0] in_green,
  input logic [7:0] in_blue,
  input logic [7:0] in_alpha,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_dest_x,
  input logic [6:0] out_dest_y,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  `E2C_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_dest_x) && $stable(out_dest_y) && $stable(out_red) && $stable(out_alpha), "Stalled result beat changed")
  `E2C_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "Result beat shown right after reset")
  `E2C_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "Input stalled with an empty output register")

endmodule

bind equirect_to_cube_cross_resampler_unit e2c_checker u_e2c_checker (.*);
